// ----- rtl/graph_bridge_edge_check_assert.svh -----
// assertion macros for the bridge edge checker
`ifndef GRAPH_BRIDGE_EDGE_CHECK_ASSERT_SVH
`define GRAPH_BRIDGE_EDGE_CHECK_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GBEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define GBEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gbec_pkg.sv -----
// shared types and constants of the bridge edge checker
`default_nettype none

package gbec_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned VertW          = 6;
  localparam int unsigned CntW           = 7;
  localparam int unsigned CmdW           = 2;

  localparam logic [CntW-1:0] VertexCountRst = 7'd64;

  // command codes
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_SRC,
    ST_WR_DST,
    ST_Q_SRC,
    ST_Q_DST,
    ST_SEARCH,
    ST_DONE
  } gbec_state_e;

  // memory control group from sequencer to adjacency store
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } gbec_mem_ctl_t;

  // finished result from sequencer to output stage
  typedef struct packed {
    logic load;
    logic essential;
    logic index_error;
  } gbec_res_t;

endpackage

`default_nettype wire

// ----- rtl/gbec_adj_mem.sv -----
// adjacency row store with per-row valid bits and registered read
`default_nettype none

module gbec_adj_mem import gbec_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  localparam int unsigned AddrW      = $clog2(MaxVertices)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire gbec_mem_ctl_t          ctl_i,
  input  wire logic [AddrW-1:0]       rd_addr_i,
  input  wire logic [AddrW-1:0]       wr_addr_i,
  input  wire logic [MaxVertices-1:0] wr_data_i,
  output logic      [MaxVertices-1:0] rd_data_o
);

  logic [MaxVertices-1:0] mem_q [MaxVertices];
  logic [MaxVertices-1:0] rdata_q;
  logic [MaxVertices-1:0] valid_q;
  logic                   rvalid_q;

  // row array, one write and one read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // row valid bits, an unwritten row reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- rtl/gbec_ctrl.sv -----
// command sequencer: edge writes, degree checks and frontier search
`default_nettype none

module gbec_ctrl import gbec_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  localparam int unsigned AddrW      = $clog2(MaxVertices)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_wr_en_i,
  input  wire logic [CntW-1:0]        cfg_wr_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CmdW-1:0]        cmd_i,
  input  wire logic [VertW-1:0]       src_vertex_i,
  input  wire logic [VertW-1:0]       dst_vertex_i,
  input  wire logic                   edge_value_i,
  output gbec_mem_ctl_t               mem_ctl_o,
  output logic      [AddrW-1:0]       mem_rd_addr_o,
  output logic      [AddrW-1:0]       mem_wr_addr_o,
  output logic      [MaxVertices-1:0] mem_wr_data_o,
  input  wire logic [MaxVertices-1:0] mem_rd_data_i,
  input  wire logic                   out_free_i,
  output gbec_res_t                   res_o
);

  localparam logic [CntW-1:0]        MaxCnt = CntW'(MaxVertices);
  localparam logic [MaxVertices-1:0] OneHot = MaxVertices'(1);

  gbec_state_e state_q, state_d;

  logic [CntW-1:0]        vcount_q;
  logic [AddrW-1:0]       s_q, s_d, d_q, d_d;
  logic                   val_q, val_d;
  logic                   ess_q, ess_d, err_q, err_d;
  logic [MaxVertices-1:0] visit_q, visit_d, pend_q, pend_d;
  logic                   infl_q, infl_d;

  logic [CntW-1:0]        live_cnt;
  logic [MaxVertices-1:0] mask;
  logic                   in_err;
  logic [MaxVertices-1:0] sbit, dbit_raw, dbit;
  logic [MaxVertices-1:0] rowm, fresh, pick, flip_bit;
  logic [AddrW-1:0]       pick_idx;
  logic                   hit;

  // true when exactly one bit is set
  function automatic logic one_bit(input logic [MaxVertices-1:0] x);
    return (x != '0) && ((x & (x - OneHot)) == '0);
  endfunction

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountRst;
    end else if (cfg_wr_en_i) begin
      vcount_q <= cfg_wr_data_i;
    end
  end

  // live vertex count and column mask
  assign live_cnt = (vcount_q > MaxCnt) ? MaxCnt : vcount_q;

  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      mask[i] = (CntW'(i) < live_cnt);
    end
  end

  assign in_err = ({1'b0, src_vertex_i} >= live_cnt) || ({1'b0, dst_vertex_i} >= live_cnt);

  // endpoint one-hots
  assign sbit     = OneHot << s_q;
  assign dbit_raw = OneHot << d_q;
  assign dbit     = (s_q == d_q) ? '0 : dbit_raw;

  // search datapath: returned row, new vertices, next vertex to expand
  assign rowm  = mem_rd_data_i & mask;
  assign hit   = infl_q && ((rowm & dbit) != '0);
  assign fresh = infl_q ? (rowm & ~visit_q & ~dbit) : '0;
  assign pick  = pend_q & (~pend_q + OneHot);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | AddrW'(i);
      end
    end
  end

  // bit flipped by an edge write in each half of the update
  assign flip_bit = (state_q == ST_WR_SRC) ? dbit_raw : sbit;

  // next state and outputs
  always_comb begin
    state_d       = state_q;
    s_d           = s_q;
    d_d           = d_q;
    val_d         = val_q;
    ess_d         = ess_q;
    err_d         = err_q;
    visit_d       = visit_q;
    pend_d        = pend_q;
    infl_d        = infl_q;
    mem_ctl_o     = '0;
    mem_rd_addr_o = d_q;
    mem_wr_addr_o = s_q;
    mem_wr_data_o = val_q ? (mem_rd_data_i | flip_bit) : (mem_rd_data_i & ~flip_bit);
    res_o         = '0;
    in_stall_o    = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        mem_rd_addr_o = src_vertex_i[AddrW-1:0];
        if (in_valid_i) begin
          s_d   = src_vertex_i[AddrW-1:0];
          d_d   = dst_vertex_i[AddrW-1:0];
          val_d = edge_value_i;
          ess_d = 1'b0;
          err_d = 1'b0;
          state_d = ST_DONE;
          case (cmd_i)
            CMD_CLEAR: begin
              mem_ctl_o.clr = 1'b1;
            end
            CMD_WRITE: begin
              err_d = in_err;
              if (!in_err) begin
                mem_ctl_o.rd = 1'b1;
                state_d      = ST_WR_SRC;
              end
            end
            CMD_QUERY: begin
              err_d = in_err;
              if (!in_err) begin
                mem_ctl_o.rd = 1'b1;
                state_d      = ST_Q_SRC;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // row of src back: update it, fetch row of dst unless it is a self loop
      ST_WR_SRC: begin
        mem_ctl_o.wr = 1'b1;
        if (s_q == d_q) begin
          state_d = ST_DONE;
        end else begin
          mem_ctl_o.rd = 1'b1;
          state_d      = ST_WR_DST;
        end
      end

      ST_WR_DST: begin
        mem_ctl_o.wr  = 1'b1;
        mem_wr_addr_o = d_q;
        state_d       = ST_DONE;
      end

      // row of src back: degree check and first frontier
      ST_Q_SRC: begin
        if (one_bit(rowm)) begin
          state_d = ST_DONE;
        end else begin
          pend_d       = rowm & ~sbit & ~dbit;
          visit_d      = sbit | (rowm & ~sbit & ~dbit);
          mem_ctl_o.rd = 1'b1;
          state_d      = ST_Q_DST;
        end
      end

      // row of dst back: degree check
      ST_Q_DST: begin
        infl_d = 1'b0;
        if (one_bit(rowm)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SEARCH;
        end
      end

      // one frontier vertex expanded per cycle while the pending set is not empty
      ST_SEARCH: begin
        mem_rd_addr_o = pick_idx;
        if (hit) begin
          ess_d   = 1'b0;
          infl_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          visit_d = visit_q | fresh;
          pend_d  = (pend_q & ~pick) | fresh;
          if (pend_q != '0) begin
            mem_ctl_o.rd = 1'b1;
            infl_d       = 1'b1;
          end else begin
            infl_d = 1'b0;
            if (fresh == '0) begin
              ess_d   = 1'b1;
              state_d = ST_DONE;
            end
          end
        end
      end

      // hand the result to the output stage
      ST_DONE: begin
        if (out_free_i) begin
          res_o.load        = 1'b1;
          res_o.essential   = ess_q;
          res_o.index_error = err_q;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      infl_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      infl_q  <= infl_d;
    end
  end

  // command fields, search sets and pending result
  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    d_q     <= d_d;
    val_q   <= val_d;
    ess_q   <= ess_d;
    err_q   <= err_d;
    visit_q <= visit_d;
    pend_q  <= pend_d;
  end

endmodule

`default_nettype wire

// ----- rtl/gbec_out_reg.sv -----
// result output register with valid and stall
`default_nettype none

module gbec_out_reg import gbec_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire gbec_res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output logic           essential_o,
  output logic           index_error_o
);

  logic valid_q;
  logic ess_q, err_q;

  // slot is free when empty or its result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      ess_q <= res_i.essential;
      err_q <= res_i.index_error;
    end
  end

  assign out_valid_o   = valid_q;
  assign essential_o   = ess_q;
  assign index_error_o = err_q;

endmodule

`default_nettype wire

// ----- rtl/graph_bridge_edge_check.sv -----
// top level of the bridge edge checker
`default_nettype none
`include "graph_bridge_edge_check_assert.svh"

// Keeps an undirected graph as a symmetric adjacency bit matrix in a
// one-read, one-write row memory and answers whether an edge (src,dst) is
// essential. One command is in flight at a time; a new transfer is taken
// while the previous result still waits in the output register. A clear,
// an out-of-range or an unused command goes straight to the result; an edge
// write is a read-modify-write of row src, then of row dst (of row src only
// for a self loop). A query reads row src, then row dst, with a degree check
// on each, and searches only if both pass: it expands one pending vertex per
// row read and waits whenever the pending set runs dry before the returned
// row adds a new vertex, as on a long path. The search speed is set by the
// single memory read port, one adjacency row a cycle, with no bypass of new
// vertices into the next read. The store is empty after reset and after a
// clear at once, through one valid flip-flop per row; there is no clearing
// pass.
module graph_bridge_edge_check import gbec_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_wr_en_i,
  input  wire logic [CntW-1:0]  cfg_wr_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CmdW-1:0]  cmd_i,
  input  wire logic [VertW-1:0] src_vertex_i,
  input  wire logic [VertW-1:0] dst_vertex_i,
  input  wire logic             edge_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  essential_o,
  output logic                  index_error_o
);

  localparam int unsigned AddrW = $clog2(MaxVertices);

  gbec_mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]       mem_rd_addr, mem_wr_addr;
  logic [MaxVertices-1:0] mem_wr_data, mem_rd_data;
  gbec_res_t              res;
  logic                   out_free;

  // sequencer
  gbec_ctrl #(
    .MaxVertices(MaxVertices)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .src_vertex_i  (src_vertex_i),
    .dst_vertex_i  (dst_vertex_i),
    .edge_value_i  (edge_value_i),
    .mem_ctl_o     (mem_ctl),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data),
    .out_free_i    (out_free),
    .res_o         (res)
  );

  // adjacency store
  gbec_adj_mem #(
    .MaxVertices(MaxVertices)
  ) u_adj_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  // output stage
  gbec_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .essential_o   (essential_o),
    .index_error_o (index_error_o)
  );

  // checks
  `GBEC_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o, "input taken while a command is in flight")
  `GBEC_ASSERT_NOW(a_load_needs_room, res.load, out_free, "result loaded over a waiting result")
  `GBEC_ASSERT_NOW(a_no_write_on_clear, mem_ctl.clr, !mem_ctl.wr, "row write during clear")
  `GBEC_ASSERT_NOW(a_err_not_essential, out_valid_o && index_error_o, !essential_o, "essential flagged on an index error")

endmodule

`default_nettype wire
